@@ src/c2p_pkg.sv @@
package c2p_pkg;

	// Port widths
	localparam int IN_W  = 16;
	localparam int MAG_W = 16;
	localparam int ANG_W = 15;

	// Internal widths: CORDIC x/y hold |v| << 16 plus gain, z is in 2^-22 degree
	localparam int X_W = 35;
	localparam int Z_W = 31;

	// Sum of squares and its root
	localparam int SQ_W   = 31;
	localparam int SUM_W  = 32;
	localparam int ROOT_W = 16;

	// Squares, sum, one stage per root bit, rounding
	localparam int SQRT_LAT = ROOT_W + 3;

	// Angle constants in 1/64 degree
	localparam logic [ANG_W-1:0] HALF_TURN = 15'd11520;
	localparam logic [ANG_W-1:0] FULL_TURN = 15'd23040;

	// 90 degrees in 2^-22 degree units
	localparam logic signed [Z_W-1:0] Z_QUARTER = 31'sd377487360;
	localparam logic signed [Z_W-1:0] Z_HALF_LSB = 31'sd32768;

	// atan(2^-i) in 2^-22 degree units
	localparam int ATAN_ENTRIES = 24;
	localparam logic signed [Z_W-1:0] ATAN_DEG_Q22 [ATAN_ENTRIES] = '{
		31'sd188743680, 31'sd111421900, 31'sd58872272, 31'sd29884485,
		31'sd15000234,  31'sd7507429,   31'sd3754631,  31'sd1877430,
		31'sd938729,    31'sd469366,    31'sd234683,   31'sd117342,
		31'sd58671,     31'sd29335,     31'sd14668,    31'sd7334,
		31'sd3667,      31'sd1833,      31'sd917,      31'sd458,
		31'sd229,       31'sd115,       31'sd57,       31'sd29
	};

	// Sign information carried alongside the CORDIC data
	typedef struct packed {
		logic re_neg;
		logic im_neg;
	} c2p_quad_t;

endpackage

@@ src/c2p_delay.sv @@
module c2p_delay #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	// Plain register chain for latency matching
	if (DEPTH == 0) begin : g_none
		assign dout = din;
	end else begin : g_line
		logic [WIDTH-1:0] dly_q [DEPTH];

		always_ff @(posedge clk) begin
			dly_q[0] <= din;
			for (int k = 1; k < DEPTH; k++) begin
				dly_q[k] <= dly_q[k-1];
			end
		end

		assign dout = dly_q[DEPTH-1];
	end

endmodule

@@ src/c2p_sqrt.sv @@
module c2p_sqrt (
	input  logic                       clk,
	input  logic [c2p_pkg::IN_W-1:0]   ax,
	input  logic [c2p_pkg::IN_W-1:0]   ay,
	output logic [c2p_pkg::MAG_W-1:0]  mag
);

	import c2p_pkg::*;

	logic [SQ_W-1:0]   sqa_s1, sqb_s1;
	logic [SUM_W-1:0]  sum_s2;
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [SUM_W-1:0]  rem_s  [ROOT_W];
	logic [MAG_W-1:0]  mag_s3;

	// Squares
	always_ff @(posedge clk) begin
		sqa_s1 <= SQ_W'(ax) * SQ_W'(ax);
		sqb_s1 <= SQ_W'(ay) * SQ_W'(ay);
	end

	// Sum of squares
	always_ff @(posedge clk) begin
		sum_s2 <= SUM_W'(sqa_s1) + SUM_W'(sqb_s1);
	end

	// One root bit per stage, MSB first; rem tracks sum - root^2
	for (genvar j = 0; j < ROOT_W; j++) begin : g_digit
		localparam int K = ROOT_W - 1 - j;
		logic [ROOT_W-1:0] root_in;
		logic [SUM_W-1:0]  rem_in;
		logic [SUM_W+1:0]  trial;

		if (j == 0) begin : g_first
			assign root_in = '0;
			assign rem_in  = sum_s2;
		end else begin : g_next
			assign root_in = root_s[j-1];
			assign rem_in  = rem_s[j-1];
		end

		// (r + 2^K)^2 - r^2
		assign trial = ((SUM_W+2)'(root_in) << (K + 1)) + ((SUM_W+2)'(1) << (2 * K));

		always_ff @(posedge clk) begin
			if ((SUM_W+2)'(rem_in) >= trial) begin
				rem_s[j]  <= SUM_W'((SUM_W+2)'(rem_in) - trial);
				root_s[j] <= root_in | (ROOT_W'(1) << K);
			end else begin
				rem_s[j]  <= rem_in;
				root_s[j] <= root_in;
			end
		end
	end

	// Round to nearest: bump when the remainder exceeds the root
	always_ff @(posedge clk) begin
		if (rem_s[ROOT_W-1] > SUM_W'(root_s[ROOT_W-1])) begin
			mag_s3 <= MAG_W'(root_s[ROOT_W-1]) + MAG_W'(1);
		end else begin
			mag_s3 <= MAG_W'(root_s[ROOT_W-1]);
		end
	end

	assign mag = mag_s3;

endmodule

@@ src/c2p_cordic.sv @@
module c2p_cordic #(
	parameter int N_STAGES = 16
) (
	input  logic                      clk,
	input  logic [c2p_pkg::IN_W-1:0]  ax,
	input  logic [c2p_pkg::IN_W-1:0]  ay,
	input  c2p_pkg::c2p_quad_t        quad,
	output logic [c2p_pkg::ANG_W-1:0] angle
);

	import c2p_pkg::*;

	logic signed [X_W-1:0] x_s [N_STAGES];
	logic signed [X_W-1:0] y_s [N_STAGES];
	logic signed [Z_W-1:0] z_s [N_STAGES];
	c2p_quad_t             q_s [N_STAGES];

	logic signed [Z_W-1:0] z_clamp, z_rnd;
	logic [12:0]           t_first;
	logic [ANG_W-1:0]      ang_map;
	logic [ANG_W-1:0]      ang_sf;

	// Vectoring micro-rotations, one per stage
	for (genvar j = 0; j < N_STAGES; j++) begin : g_rot
		logic signed [X_W-1:0] x_in, y_in;
		logic signed [Z_W-1:0] z_in;
		c2p_quad_t             q_in;

		if (j == 0) begin : g_first
			assign x_in = X_W'({ax, 16'h0000});
			assign y_in = X_W'({ay, 16'h0000});
			assign z_in = '0;
			assign q_in = quad;
		end else begin : g_next
			assign x_in = x_s[j-1];
			assign y_in = y_s[j-1];
			assign z_in = z_s[j-1];
			assign q_in = q_s[j-1];
		end

		always_ff @(posedge clk) begin
			q_s[j] <= q_in;
			if (y_in > 0) begin
				x_s[j] <= x_in + (y_in >>> j);
				y_s[j] <= y_in - (x_in >>> j);
				z_s[j] <= z_in + ATAN_DEG_Q22[j];
			end else begin
				x_s[j] <= x_in - (y_in >>> j);
				y_s[j] <= y_in + (x_in >>> j);
				z_s[j] <= z_in - ATAN_DEG_Q22[j];
			end
		end
	end

	// Clamp to 0..90 deg, round to 1/64 deg, map back to the sample's quadrant
	always_comb begin
		if (z_s[N_STAGES-1] < 0) begin
			z_clamp = '0;
		end else if (z_s[N_STAGES-1] > Z_QUARTER) begin
			z_clamp = Z_QUARTER;
		end else begin
			z_clamp = z_s[N_STAGES-1];
		end
		z_rnd   = z_clamp + Z_HALF_LSB;
		t_first = z_rnd[28:16];

		if (!q_s[N_STAGES-1].im_neg) begin
			ang_map = q_s[N_STAGES-1].re_neg ? HALF_TURN - ANG_W'(t_first) : ANG_W'(t_first);
		end else begin
			ang_map = q_s[N_STAGES-1].re_neg ? HALF_TURN + ANG_W'(t_first)
			                                 : FULL_TURN - ANG_W'(t_first);
		end
		if (ang_map == FULL_TURN) begin
			ang_map = '0;
		end
	end

	always_ff @(posedge clk) begin
		ang_sf <= ang_map;
	end

	assign angle = ang_sf;

endmodule

@@ src/complex_to_polar_degrees.sv @@
// Channel   Direction  Handshake            Payload
// command   in         start (busy low)     real_part, imag_part
// result    out        done, one cycle      magnitude, angle
//
// One transaction enters per clock; busy is never raised.
// The delay from start to done is set by the slower of the 16-stage
// bit-per-stage square root and the CORDIC rotation stages.
// Reset clears only the valid bits; data stages run freely.
// The receiver cannot stall, so results are never held back.
module complex_to_polar_degrees #(
	parameter int ITERATIONS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [c2p_pkg::IN_W-1:0]   real_part,
	input  logic signed [c2p_pkg::IN_W-1:0]   imag_part,
	output logic                              done,
	output logic [c2p_pkg::MAG_W-1:0]         magnitude,
	output logic [c2p_pkg::ANG_W-1:0]         angle
);

	import c2p_pkg::*;

	localparam int NITER      = (ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : ITERATIONS;
	localparam int CORDIC_LAT = NITER + 1;
	localparam int LAT        = (SQRT_LAT > CORDIC_LAT) ? SQRT_LAT : CORDIC_LAT;

	logic            v_s1;
	logic [IN_W-1:0] ax_s1, ay_s1;
	c2p_quad_t       quad_s1;
	logic [LAT-1:0]  vld_q;
	logic [MAG_W-1:0] mag_raw;
	logic [ANG_W-1:0] ang_raw;

	assign busy = 1'b0;

	// Input stage: magnitudes of both parts and their signs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1          <= real_part[IN_W-1] ? IN_W'(-real_part) : IN_W'(real_part);
		ay_s1          <= imag_part[IN_W-1] ? IN_W'(-imag_part) : IN_W'(imag_part);
		quad_s1.re_neg <= real_part[IN_W-1];
		quad_s1.im_neg <= imag_part[IN_W-1];
	end

	// Valid bits following the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], v_s1};
		end
	end

	assign done = vld_q[LAT-1];

	// Magnitude path
	c2p_sqrt u_sqrt (
		.clk (clk),
		.ax  (ax_s1),
		.ay  (ay_s1),
		.mag (mag_raw)
	);

	c2p_delay #(.WIDTH(MAG_W), .DEPTH(LAT - SQRT_LAT)) u_mag_dly (
		.clk  (clk),
		.din  (mag_raw),
		.dout (magnitude)
	);

	// Angle path
	c2p_cordic #(.N_STAGES(NITER)) u_cordic (
		.clk   (clk),
		.ax    (ax_s1),
		.ay    (ay_s1),
		.quad  (quad_s1),
		.angle (ang_raw)
	);

	c2p_delay #(.WIDTH(ANG_W), .DEPTH(LAT - CORDIC_LAT)) u_ang_dly (
		.clk  (clk),
		.din  (ang_raw),
		.dout (angle)
	);

	// Each result lines up with an earlier accepted transaction
	a_done_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(v_s1, LAT))
		else $error("result strobe without matching transaction");

	// Zero magnitude exactly for a zero sample
	a_mag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((magnitude == '0) == ($past(ax_s1, LAT) == '0 && $past(ay_s1, LAT) == '0)))
		else $error("magnitude zero mismatch");

	// Negative imaginary part lands in the lower half plane
	a_lower_half: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(quad_s1.im_neg, LAT)) |-> (angle >= HALF_TURN || angle == '0))
		else $error("angle outside lower half plane");

	// Non-negative imaginary part lands in the upper half plane
	a_upper_half: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !$past(quad_s1.im_neg, LAT)) |-> (angle <= HALF_TURN))
		else $error("angle outside upper half plane");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import c2p_pkg::*;

	localparam int CORDIC_STEPS = 16;
	localparam int DRAIN_CYCLES = 60;
	localparam int RANDOM_ITEMS = 1425;

	// Angle turn points in 1/64 degree, z scale is 2^-22 degree
	localparam longint TURN_HALF = 11520;
	localparam longint TURN_FULL = 23040;
	localparam longint Z_RIGHT_ANGLE = longint'(90) << 22;

	// atan(2^-i) in 2^-22 degree, rounded to nearest
	localparam longint ARCTAN_Q22 [24] = '{
		188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
		3754631, 1877430, 938729, 469366, 234683, 117342,
		58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29
	};

	typedef struct {
		logic signed [IN_W-1:0] re;
		logic signed [IN_W-1:0] im;
		int unsigned            gap;
	} sample_t;

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic [ANG_W-1:0] ang;
	} polar_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic signed [IN_W-1:0]  real_part = '0;
	logic signed [IN_W-1:0]  imag_part = '0;
	logic                    done;
	logic [MAG_W-1:0]        magnitude;
	logic [ANG_W-1:0]        angle;

	sample_t     sample_queue[$];
	polar_t      polar_due[$];
	sample_t     cur_sample;
	bit          cur_loaded = 1'b0;
	int unsigned idle_left = 0;
	bit          took = 1'b0;
	int          n_total = 0;
	int          n_accepted = 0;
	int          n_checked = 0;
	int          n_errors = 0;
	int          n_zero = 0;
	int          n_axis = 0;
	int          n_quad [4] = '{0, 0, 0, 0};

	complex_to_polar_degrees #(
		.ITERATIONS(CORDIC_STEPS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.real_part(real_part),
		.imag_part(imag_part),
		.done     (done),
		.magnitude(magnitude),
		.angle    (angle)
	);

	always #2 clk = ~clk;

	// Expected magnitude and angle of one complex sample
	function automatic polar_t polar_of(logic signed [IN_W-1:0] re,
	                                   logic signed [IN_W-1:0] im);
		longint a_re, a_im, sq, root, bit_v, rem_v, x, y, z, dx, dy, quarter, turn;
		polar_t res;
		a_re = (re < 0) ? -longint'(re) : longint'(re);
		a_im = (im < 0) ? -longint'(im) : longint'(im);
		res = '0;
		if (re == 0 && im == 0) begin
			return res;
		end
		// bit-by-bit square root, then round half up
		sq = a_re * a_re + a_im * a_im;
		rem_v = sq;
		root = 0;
		bit_v = longint'(1) << 40;
		while (bit_v > rem_v)
			bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (rem_v >= root + bit_v) begin
				rem_v = rem_v - (root + bit_v);
				root = (root >> 1) + bit_v;
			end else begin
				root = root >> 1;
			end
			bit_v = bit_v >> 2;
		end
		if (sq - root * root > root)
			root++;
		// vectoring over the first-quadrant image
		x = a_re * 65536;
		y = a_im * 65536;
		z = 0;
		for (int i = 0; i < ((CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS); i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x = x + dx;
				y = y - dy;
				z = z + ARCTAN_Q22[i];
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - ARCTAN_Q22[i];
			end
		end
		if (z < 0)
			z = 0;
		if (z > Z_RIGHT_ANGLE)
			z = Z_RIGHT_ANGLE;
		quarter = (z + (longint'(1) << 15)) >>> 16;
		// back to the quadrant of the sample
		if (im >= 0)
			turn = (re >= 0) ? quarter : TURN_HALF - quarter;
		else
			turn = (re < 0) ? TURN_HALF + quarter : TURN_FULL - quarter;
		if (turn >= TURN_FULL)
			turn = turn - TURN_FULL;
		res.mag = root[MAG_W-1:0];
		res.ang = turn[ANG_W-1:0];
		return res;
	endfunction

	// Idle cycles ahead of a transaction: mostly none or short, a few long
	function automatic int unsigned pick_gap(bit burst);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (burst || r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	task automatic add_sample(int re, int im, int unsigned gap);
		sample_t s;
		s.re = re[IN_W-1:0];
		s.im = im[IN_W-1:0];
		s.gap = gap;
		sample_queue.push_back(s);
		n_total++;
	endtask

	// Driver: presents queued transactions at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !took) begin
			// not accepted yet, hold everything
		end else begin
			if (!cur_loaded && sample_queue.size() != 0) begin
				cur_sample = sample_queue.pop_front();
				idle_left = cur_sample.gap;
				cur_loaded = 1'b1;
			end
			if (cur_loaded && idle_left == 0) begin
				start <= 1'b1;
				real_part <= cur_sample.re;
				imag_part <= cur_sample.im;
				cur_loaded = 1'b0;
			end else begin
				if (idle_left != 0)
					idle_left--;
				start <= 1'b0;
				real_part <= IN_W'($urandom);
				imag_part <= IN_W'($urandom);
			end
		end
	end

	// Monitor: checks results, then records newly accepted transactions
	always @(posedge clk) begin
		polar_t want;
		if (arst_n) begin
			took <= start && !busy;
			if (done) begin
				if (polar_due.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("%t: result with nothing pending: magnitude %0d angle %0d",
						         $realtime, magnitude, angle);
				end else begin
					want = polar_due.pop_front();
					n_checked++;
					if (magnitude !== want.mag || angle !== want.ang) begin
						n_errors++;
						if (n_errors <= 10)
							$display("%t: expected magnitude %0d angle %0d, got %0d %0d",
							         $realtime, want.mag, want.ang, magnitude, angle);
					end
				end
			end
			if (start && !busy) begin
				polar_due.push_back(polar_of(real_part, imag_part));
				n_accepted++;
				if (real_part == 0 && imag_part == 0)
					n_zero++;
				else if (real_part == 0 || imag_part == 0)
					n_axis++;
				else
					n_quad[{imag_part < 0, (real_part < 0) ^ (imag_part < 0)}]++;
			end
		end else begin
			took <= 1'b0;
		end
	end

	// Stimulus and end of run
	initial begin
		int r, a, b;
		bit burst;
		// extremes, axes, diagonals, zero and near-wrap cases
		add_sample(0, 0, 0);
		add_sample(32767, 0, 0);
		add_sample(-32768, 0, 0);
		add_sample(0, 32767, 1);
		add_sample(0, -32768, 0);
		add_sample(-32768, -32768, 0);
		add_sample(32767, 32767, 2);
		add_sample(-32768, 32767, 0);
		add_sample(32767, -32768, 0);
		add_sample(1, 0, 0);
		add_sample(0, 1, 0);
		add_sample(-1, 0, 3);
		add_sample(0, -1, 0);
		add_sample(1, 1, 0);
		add_sample(-1, -1, 0);
		add_sample(1, -1, 0);
		add_sample(-1, 1, 0);
		add_sample(32767, -1, 0);
		add_sample(-32768, -1, 0);
		add_sample(-32768, 1, 5);
		add_sample(32767, 1, 0);
		add_sample(0, 5, 0);
		add_sample(5, 0, 0);
		add_sample(-3, 4, 0);
		add_sample(0, 0, 0);
		// random part: full range, small values, near an axis, extremes
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			burst = ((n / 150) % 3) == 1;
			r = $urandom_range(0, 99);
			if (r < 45) begin
				a = $signed(16'($urandom));
				b = $signed(16'($urandom));
			end else if (r < 65) begin
				a = $urandom_range(0, 16) - 8;
				b = $urandom_range(0, 16) - 8;
			end else if (r < 82) begin
				a = $signed(16'($urandom));
				b = $urandom_range(0, 6) - 3;
				if ($urandom_range(0, 1))
					{a, b} = {b, a};
			end else begin
				a = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3)
				                         : -32768 + $urandom_range(0, 3);
				b = $urandom_range(0, 1) ? a + $urandom_range(0, 2) - 1
				                         : int'($signed(16'($urandom)));
				if (b > 32767)
					b = 32767;
				if (b < -32768)
					b = -32768;
				if ($urandom_range(0, 1))
					{a, b} = {b, a};
			end
			add_sample(a, b, pick_gap(burst));
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (n_accepted == n_total);
		wait (polar_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d transactions sent, %0d results checked, %0d mismatches",
		         n_accepted, n_checked, n_errors);
		$display("zero %0d, on an axis %0d, quadrants I-IV %0d %0d %0d %0d",
		         n_zero, n_axis, n_quad[0], n_quad[1], n_quad[2], n_quad[3]);
		if (n_errors == 0 && polar_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("timeout: %0d of %0d accepted, %0d results pending",
		         n_accepted, n_total, polar_due.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ filelist.f @@
src/c2p_pkg.sv
src/c2p_delay.sv
src/c2p_sqrt.sv
src/c2p_cordic.sv
src/complex_to_polar_degrees.sv
sim/testbench.sv
